@@ src/skset_pkg.sv @@
`default_nettype none

package skset_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 64;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 64;
    localparam int COUNT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_CONTAINS = 2'd2
    } skset_mode_t;

    typedef enum logic [1:0] {
        ST_FALSE = 2'd0,
        ST_TRUE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } skset_status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_UPDATE = 1'b1
    } skset_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } skset_req_t;

    typedef struct packed {
        skset_status_t      status;
        logic [COUNT_W-1:0] count;
    } skset_res_t;

    // per-cycle command shared by every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } skset_ctl_t;

    // compare result held by a cell from the compare until the update
    typedef struct packed {
        logic ge;
        logic eq;
    } skset_flags_t;

endpackage

`default_nettype wire

@@ src/skset_cell.sv @@
`default_nettype none

module skset_cell #(
    parameter int KEY_WIDTH = skset_pkg::KEY_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire skset_pkg::skset_ctl_t ctl,
    input  wire logic                  occupied,
    input  wire logic [KEY_WIDTH-1:0]  probe,
    input  wire logic [KEY_WIDTH-1:0]  req_key,
    input  wire logic [KEY_WIDTH-1:0]  left_key,
    input  wire logic                  left_ge,
    input  wire logic [KEY_WIDTH-1:0]  right_key,
    output logic [KEY_WIDTH-1:0]       key,
    output skset_pkg::skset_flags_t    flags
);

    logic [KEY_WIDTH-1:0]    key_reg;
    logic [KEY_WIDTH-1:0]    key_next;
    skset_pkg::skset_flags_t flags_reg;
    skset_pkg::skset_flags_t flags_next;

    always_comb
    begin
        flags_next = flags_reg;
        if (ctl.cmp)
        begin
            // an empty cell counts as holding a key above everything
            flags_next.ge = !occupied || (key_reg > probe);
            flags_next.eq = occupied && (key_reg == probe);
        end
    end

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins && flags_reg.ge)
        begin
            key_next = left_ge ? left_key : req_key;
        end
        else if (ctl.del && (flags_reg.ge || flags_reg.eq))
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

@@ src/sorted_key_set.sv @@
// channel   | signals                    | transfer condition
// ----------+----------------------------+-------------------------------
// request   | req.mode, req.key          | start high while busy low
// result    | res.status, res.count      | done high, one cycle per result
//
// for each request, at the accepting edge every cell compares
// its key with the request key; in the busy cycle that follows the cells
// shift by one place for an add or remove, and the result is registered.
// done is high in the cycle after busy, so a new request can be taken then.
// reset clears the count and control; stored keys are meaningless until written.
// the result cannot be stalled: done lasts exactly one cycle.
`default_nettype none

module sorted_key_set #(
    parameter int CAPACITY  = skset_pkg::CAPACITY,
    parameter int KEY_WIDTH = skset_pkg::KEY_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire skset_pkg::skset_req_t req,
    output logic                       busy,
    output logic                       done,
    output skset_pkg::skset_res_t      res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    skset_pkg::skset_state_t state_reg;
    skset_pkg::skset_state_t state_next;
    logic [1:0]              mode_reg;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    done_reg;
    logic                    done_next;
    skset_pkg::skset_res_t   res_reg;
    skset_pkg::skset_res_t   res_next;
    skset_pkg::skset_status_t status;
    skset_pkg::skset_ctl_t   ctl;
    logic                    accept;
    logic                    found;
    logic                    do_ins;
    logic                    do_del;
    logic [KEY_WIDTH-1:0]    probe;

    logic [KEY_WIDTH-1:0]    cell_key [CAPACITY];
    skset_pkg::skset_flags_t cell_flags [CAPACITY];
    logic [CAPACITY-1:0]     eq_vec;

    assign busy   = (state_reg == skset_pkg::S_UPDATE);
    assign accept = start && !busy;
    assign probe  = req.key[KEY_WIDTH-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] left_key;
            logic                 left_ge;
            logic [KEY_WIDTH-1:0] right_key;
            logic                 occupied;

            if (gi == 0)
            begin : g_first
                assign left_key = key_reg;
                assign left_ge  = 1'b0;
            end
            else
            begin : g_mid
                assign left_key = cell_key[gi-1];
                assign left_ge  = cell_flags[gi-1].ge;
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_key = cell_key[gi];
            end
            else
            begin : g_next
                assign right_key = cell_key[gi+1];
            end

            assign occupied = (CNT_W'(gi) < count_reg);

            skset_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .occupied  (occupied),
                .probe     (probe),
                .req_key   (key_reg),
                .left_key  (left_key),
                .left_ge   (left_ge),
                .right_key (right_key),
                .key       (cell_key[gi]),
                .flags     (cell_flags[gi])
            );

            assign eq_vec[gi] = cell_flags[gi].eq;
        end
    endgenerate

    assign found = |eq_vec;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        status     = skset_pkg::ST_FALSE;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        done_next  = 1'b0;
        case (state_reg)
            skset_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = skset_pkg::S_UPDATE;
                end
            end
            skset_pkg::S_UPDATE:
            begin
                state_next = skset_pkg::S_IDLE;
                done_next  = 1'b1;
                if (key_reg == '0)
                begin
                    status = skset_pkg::ST_ZERO;
                end
                else
                begin
                    case (mode_reg)
                        skset_pkg::MODE_ADD:
                        begin
                            if (found)
                            begin
                                status = skset_pkg::ST_FALSE;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status = skset_pkg::ST_FULL;
                            end
                            else
                            begin
                                status     = skset_pkg::ST_TRUE;
                                do_ins     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        skset_pkg::MODE_REMOVE:
                        begin
                            if (found)
                            begin
                                status     = skset_pkg::ST_TRUE;
                                do_del     = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        skset_pkg::MODE_CONTAINS:
                        begin
                            status = found ? skset_pkg::ST_TRUE : skset_pkg::ST_FALSE;
                        end
                        default:
                        begin
                            status = skset_pkg::ST_FALSE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = skset_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.cmp = accept;
        ctl.ins = do_ins;
        ctl.del = do_del;
        res_next.status = status;
        res_next.count  = skset_pkg::COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skset_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            key_reg  <= probe;
        end
        if (state_reg == skset_pkg::S_UPDATE)
        begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("result missing after update cycle");

    a_count_moves_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> (count_reg == $past(count_reg)))
        else $error("count changed outside an update cycle");

    a_full_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (res.status == skset_pkg::ST_FULL)) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full status with room left");

endmodule

`default_nettype wire
